// ===== sv/bsp_sel_pkg.sv =====
// ----------------------------------------------------------------------------
// bsp_sel_pkg
// Shared types and constants of the partition selector.
// ----------------------------------------------------------------------------
package bsp_sel_pkg;

  localparam int unsigned MAX_SEGS_DEF = 256;

  // configuration register indexes
  localparam logic [1:0] REG_SPLIT_PENALTY = 2'd0;
  localparam logic [1:0] REG_NEAR_LIMIT    = 2'd1;

  localparam logic [7:0]  SPLIT_PENALTY_RST = 8'd17;
  localparam logic [19:0] NEAR_LIMIT_RST    = 20'd131072;

  // epsilon 0.0001 in Q32.32
  localparam logic [66:0] NEAR_EPS = 67'd429497;

  localparam int unsigned SIDE_W = 67;   // side values and dot products
  localparam int unsigned PROD_W = 70;   // shared multiplier result
  localparam int unsigned OPND_W = 35;   // shared multiplier operands
  localparam int unsigned WIDE_W = 100;  // length and limit products
  localparam int unsigned CHUNK  = 34;   // low chunk of a split multiply

  localparam logic [5:0] ROOT_LAST = 6'd32;  // 33 root digits
  localparam logic [3:0] MUL_LAST  = 4'd12;
  localparam logic [3:0] SQ_LAST   = 4'd2;

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic [31:0]        len;
    logic               obl;
  } seg_t;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_SQ   = 11'b000_0000_0010,
    S_ROOT = 11'b000_0000_0100,
    S_PRD  = 11'b000_0000_1000,
    S_PLAT = 11'b000_0001_0000,
    S_CRD  = 11'b000_0010_0000,
    S_CLAT = 11'b000_0100_0000,
    S_MUL  = 11'b000_1000_0000,
    S_DEC  = 11'b001_0000_0000,
    S_PEND = 11'b010_0000_0000,
    S_DONE = 11'b100_0000_0000
  } state_t;

endpackage

// ===== sv/bsp_partition_selector_top.sv =====
// ----------------------------------------------------------------------------
// bsp_partition_selector_top
// Partition-line selector: stores segments, then scores each as a splitter.
// ----------------------------------------------------------------------------
// Load: each segment is accepted, then the two squares are formed on the shared
// multiplier, then a digit-by-digit square root gives its length; in_stall is
// high until the next segment can be accepted. Selection after the last
// segment runs the 13-step multiply sequence per segment pair on one shared
// multiplier and the single read port of the segment memory.
// Reset: synchronous, clears count, dropped and found flags and output valid,
// sets lowest cost to all ones, restores register defaults; segment memory kept.
// ----------------------------------------------------------------------------
module bsp_partition_selector_top #(
  parameter int unsigned MAX_SEGS = bsp_sel_pkg::MAX_SEGS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [19:0]              cfg_data,
  // segment input
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [31:0]       start_x,
  input  logic signed [31:0]       start_y,
  input  logic signed [31:0]       end_x,
  input  logic signed [31:0]       end_y,
  input  logic                     oblique,
  input  logic                     last_seg,
  // selection result
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [7:0]               best_index,
  output logic [30:0]              best_cost,
  output logic                     fallback,
  output logic                     overflow
);

  localparam int unsigned AW = (MAX_SEGS > 1) ? $clog2(MAX_SEGS) : 1;
  localparam int unsigned CW = $clog2(MAX_SEGS + 1);
  localparam int unsigned DW = CW + 2;
  localparam int unsigned SW = bsp_sel_pkg::SIDE_W;
  localparam int unsigned XW = bsp_sel_pkg::WIDE_W;
  localparam int unsigned OW = bsp_sel_pkg::OPND_W;
  localparam int unsigned PW = bsp_sel_pkg::PROD_W;
  localparam int unsigned CK = bsp_sel_pkg::CHUNK;

  bsp_sel_pkg::state_t state;

  // configuration registers
  logic [7:0]  split_penalty;
  logic [19:0] near_split_limit;

  // segment memory
  bsp_sel_pkg::seg_t mem [MAX_SEGS];
  bsp_sel_pkg::seg_t mem_q;
  bsp_sel_pkg::seg_t wr_data;
  logic              mem_we;
  logic              rd_en;
  logic [AW-1:0]     wr_idx;
  logic [AW-1:0]     rd_idx;

  // set bookkeeping
  logic [CW-1:0] segment_count;
  logic [31:0]   lowest_cost;
  logic          dropped;
  logic          found;
  logic [CW-1:0] best_p;

  // load path
  logic signed [31:0] ld_sx, ld_sy, ld_ex, ld_ey;
  logic               ld_obl, ld_last;
  logic signed [32:0] ldx, ldy;
  logic [65:0]        rad;
  logic [35:0]        rem;
  logic [32:0]        root;
  logic [5:0]         iter;
  logic [3:0]         step;

  // scoring path
  logic [CW-1:0]      p, c;
  logic signed [31:0] psx, psy;
  logic signed [32:0] pdx, pdy;
  logic signed [32:0] cx0, cy0, cx1, cy1, cdx, cdy;
  logic [31:0]        clen;
  logic signed [SW-1:0] side_a, side_b, dot;
  logic [SW-1:0]      ma, mb, ms;
  logic [XW-1:0]      xa, xb, xl;
  logic [31:0]        cost;
  logic [CW-1:0]      lefts, tot;

  // shared multiplier
  logic signed [OW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;

  // ---------------------------------------------------------------------------
  // Square root digit step: two radicand bits in, one root bit out.
  // ---------------------------------------------------------------------------
  logic [35:0] rem_sh, trial, rem_next;
  logic        root_ge;
  logic [32:0] root_next;
  logic [31:0] len_sat;

  always_comb begin
    rem_sh    = {rem[33:0], rad[65:64]};
    trial     = {1'b0, root, 2'b01};
    root_ge   = (rem_sh >= trial);
    rem_next  = root_ge ? (rem_sh - trial) : rem_sh;
    root_next = {root[31:0], root_ge};
    // saturate a root beyond 32 bits
    len_sat   = root_next[32] ? 32'hFFFF_FFFF : root_next[31:0];
  end

  // ---------------------------------------------------------------------------
  // Operand select for the shared multiplier.
  // ---------------------------------------------------------------------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == bsp_sel_pkg::S_SQ) begin
      mul_a = (step == 4'd0) ? OW'(ldx) : OW'(ldy);
      mul_b = mul_a;
    end else if (state == bsp_sel_pkg::S_MUL) begin
      case (step)
        4'd0: begin
          mul_a = OW'(pdy); mul_b = OW'(cx0);
        end
        4'd1: begin
          mul_a = OW'(pdx); mul_b = OW'(cy0);
        end
        4'd2: begin
          mul_a = OW'(pdy); mul_b = OW'(cx1);
        end
        4'd3: begin
          mul_a = OW'(pdx); mul_b = OW'(cy1);
        end
        4'd4: begin
          mul_a = OW'(cdx); mul_b = OW'(pdx);
        end
        4'd5: begin
          mul_a = OW'(cdy); mul_b = OW'(pdy);
        end
        4'd6: begin
          mul_a = $signed({1'b0, ma[CK-1:0]}); mul_b = $signed({3'b0, clen});
        end
        4'd7: begin
          mul_a = $signed({2'b0, ma[SW-1:CK]}); mul_b = $signed({3'b0, clen});
        end
        4'd8: begin
          mul_a = $signed({1'b0, mb[CK-1:0]}); mul_b = $signed({3'b0, clen});
        end
        4'd9: begin
          mul_a = $signed({2'b0, mb[SW-1:CK]}); mul_b = $signed({3'b0, clen});
        end
        4'd10: begin
          mul_a = $signed({1'b0, ms[CK-1:0]}); mul_b = $signed({15'b0, near_split_limit});
        end
        4'd11: begin
          mul_a = $signed({2'b0, ms[SW-1:CK]}); mul_b = $signed({15'b0, near_split_limit});
        end
        default: begin
          mul_a = '0; mul_b = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  // ---------------------------------------------------------------------------
  // Memory ports: load writes one entry, scoring reads one entry in S_PRD or S_CRD.
  // ---------------------------------------------------------------------------
  always_comb begin
    mem_we  = (state == bsp_sel_pkg::S_ROOT) && (iter == bsp_sel_pkg::ROOT_LAST);
    wr_idx  = segment_count[AW-1:0];
    wr_data = '{sx: ld_sx, sy: ld_sy, ex: ld_ex, ey: ld_ey, len: len_sat, obl: ld_obl};
    rd_en   = (state == bsp_sel_pkg::S_PRD) || (state == bsp_sel_pkg::S_CRD);
    rd_idx  = (state == bsp_sel_pkg::S_PRD) ? p[AW-1:0] : c[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_idx];
    end
  end

  // ---------------------------------------------------------------------------
  // Pair classification: split, left or neither.
  // ---------------------------------------------------------------------------
  logic a_neg, b_neg, a_pos, b_pos, opp, nza, nzb, dot_neg;
  logic is_split, is_left;

  always_comb begin
    a_neg    = side_a[SW-1];
    b_neg    = side_b[SW-1];
    a_pos    = !a_neg && (side_a != '0);
    b_pos    = !b_neg && (side_b != '0);
    opp      = (a_neg && b_pos) || (a_pos && b_neg);
    nza      = (ma < bsp_sel_pkg::NEAR_EPS);
    nzb      = (mb < bsp_sel_pkg::NEAR_EPS);
    dot_neg  = dot[SW-1];
    is_split = 1'b0;
    is_left  = 1'b0;
    if (opp) begin
      if (!nza && !nzb) begin
        if (!(xa < xl)) begin
          is_split = 1'b1;
        end else if (xb < xl) begin
          // crossing near both ends: follow the direction
          is_left = dot_neg;
        end else begin
          is_left = b_neg;
        end
      end else begin
        is_left = 1'b1;
      end
    end else begin
      is_left = !a_pos && (!nza || (nzb && dot_neg));
    end
  end

  // ---------------------------------------------------------------------------
  // Balance for the current candidate.
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] diff;
  logic [DW-1:0]        abs_diff;
  logic                 qualifies;
  logic [31:0]          total;

  always_comb begin
    diff      = $signed(DW'(segment_count)) - $signed(DW'({lefts, 1'b0}))
                - $signed(DW'(tot));
    abs_diff  = diff[DW-1] ? DW'(-diff) : DW'(diff);
    qualifies = (DW'(tot) + DW'(segment_count)) > abs_diff;
    total     = cost + 32'(abs_diff);
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign in_stall = (state != bsp_sel_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= bsp_sel_pkg::S_IDLE;
      split_penalty    <= bsp_sel_pkg::SPLIT_PENALTY_RST;
      near_split_limit <= bsp_sel_pkg::NEAR_LIMIT_RST;
      segment_count    <= '0;
      lowest_cost      <= '1;
      dropped          <= 1'b0;
      found            <= 1'b0;
      out_valid        <= 1'b0;
      step             <= '0;
      iter             <= '0;
      p                <= '0;
      c                <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bsp_sel_pkg::REG_SPLIT_PENALTY: split_penalty    <= cfg_data[7:0];
          bsp_sel_pkg::REG_NEAR_LIMIT:    near_split_limit <= cfg_data;
          default: ;
        endcase
      end

      // drop the result once taken, unless a new one replaces it right away
      if (out_valid && !out_stall && (state != bsp_sel_pkg::S_DONE)) begin
        out_valid <= 1'b0;
      end

      case (state)
        bsp_sel_pkg::S_IDLE: begin
          if (in_valid) begin
            ld_sx   <= start_x;
            ld_sy   <= start_y;
            ld_ex   <= end_x;
            ld_ey   <= end_y;
            ld_obl  <= oblique;
            ld_last <= last_seg;
            ldx     <= 33'(end_x) - 33'(start_x);
            ldy     <= 33'(end_y) - 33'(start_y);
            step    <= '0;
            p       <= '0;
            if (segment_count < CW'(MAX_SEGS)) begin
              state <= bsp_sel_pkg::S_SQ;
            end else begin
              // store full: drop the item, still honor the end of set
              dropped <= 1'b1;
              if (last_seg) begin
                state <= bsp_sel_pkg::S_PRD;
              end
            end
          end
        end

        bsp_sel_pkg::S_SQ: begin
          step <= step + 4'd1;
          if (step == 4'd1) begin
            rad <= mul_p[65:0];
          end else if (step == bsp_sel_pkg::SQ_LAST) begin
            rad   <= rad + mul_p[65:0];
            rem   <= '0;
            root  <= '0;
            iter  <= '0;
            state <= bsp_sel_pkg::S_ROOT;
          end
        end

        bsp_sel_pkg::S_ROOT: begin
          rem  <= rem_next;
          root <= root_next;
          rad  <= {rad[63:0], 2'b00};
          iter <= iter + 6'd1;
          if (iter == bsp_sel_pkg::ROOT_LAST) begin
            segment_count <= segment_count + CW'(1);
            state <= ld_last ? bsp_sel_pkg::S_PRD : bsp_sel_pkg::S_IDLE;
          end
        end

        bsp_sel_pkg::S_PRD: begin
          state <= bsp_sel_pkg::S_PLAT;
        end

        bsp_sel_pkg::S_PLAT: begin
          psx   <= mem_q.sx;
          psy   <= mem_q.sy;
          pdx   <= 33'(mem_q.ex) - 33'(mem_q.sx);
          pdy   <= 33'(mem_q.ey) - 33'(mem_q.sy);
          cost  <= mem_q.obl ? 32'(split_penalty) : '0;
          lefts <= '0;
          tot   <= '0;
          c     <= '0;
          state <= bsp_sel_pkg::S_CRD;
        end

        bsp_sel_pkg::S_CRD: begin
          state <= bsp_sel_pkg::S_CLAT;
        end

        bsp_sel_pkg::S_CLAT: begin
          cx0   <= 33'(mem_q.sx) - 33'(psx);
          cy0   <= 33'(mem_q.sy) - 33'(psy);
          cx1   <= 33'(mem_q.ex) - 33'(psx);
          cy1   <= 33'(mem_q.ey) - 33'(psy);
          cdx   <= 33'(mem_q.ex) - 33'(mem_q.sx);
          cdy   <= 33'(mem_q.ey) - 33'(mem_q.sy);
          clen  <= mem_q.len;
          step  <= '0;
          state <= bsp_sel_pkg::S_MUL;
        end

        bsp_sel_pkg::S_MUL: begin
          // each step accumulates the product issued one step earlier
          step <= step + 4'd1;
          case (step)
            4'd1:  side_a <= SW'(mul_p);
            4'd2:  side_a <= side_a - SW'(mul_p);
            4'd3:  side_b <= SW'(mul_p);
            4'd4:  side_b <= side_b - SW'(mul_p);
            4'd5: begin
              dot <= SW'(mul_p);
              ma  <= side_a[SW-1] ? SW'(-side_a) : SW'(side_a);
              mb  <= side_b[SW-1] ? SW'(-side_b) : SW'(side_b);
              ms  <= (side_a[SW-1] ? SW'(-side_a) : SW'(side_a))
                     + (side_b[SW-1] ? SW'(-side_b) : SW'(side_b));
            end
            4'd6:  dot <= dot + SW'(mul_p);
            4'd7:  xa  <= XW'(mul_p[67:0]);
            4'd8:  xa  <= xa + (XW'(mul_p[67:0]) << CK);
            4'd9:  xb  <= XW'(mul_p[67:0]);
            4'd10: xb  <= xb + (XW'(mul_p[67:0]) << CK);
            4'd11: xl  <= XW'(mul_p[67:0]);
            4'd12: xl  <= xl + (XW'(mul_p[67:0]) << CK);
            default: ;
          endcase
          if (step == bsp_sel_pkg::MUL_LAST) begin
            state <= bsp_sel_pkg::S_DEC;
          end
        end

        bsp_sel_pkg::S_DEC: begin
          if (is_split) begin
            cost <= cost + 32'(split_penalty);
            tot  <= tot + CW'(1);
          end
          if (is_left) begin
            lefts <= lefts + CW'(1);
          end
          c <= c + CW'(1);
          state <= (c == segment_count - CW'(1)) ? bsp_sel_pkg::S_PEND
                                                 : bsp_sel_pkg::S_CRD;
        end

        bsp_sel_pkg::S_PEND: begin
          if (qualifies && (total < lowest_cost)) begin
            lowest_cost <= total;
            best_p      <= p;
            found       <= 1'b1;
          end
          p <= p + CW'(1);
          state <= (p == segment_count - CW'(1)) ? bsp_sel_pkg::S_DONE
                                                 : bsp_sel_pkg::S_PRD;
        end

        bsp_sel_pkg::S_DONE: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            best_index    <= found ? 8'(best_p) : '0;
            best_cost     <= found ? lowest_cost[30:0] : '0;
            fallback      <= !found;
            overflow      <= dropped;
            segment_count <= '0;
            lowest_cost   <= '1;
            dropped       <= 1'b0;
            found         <= 1'b0;
            state         <= bsp_sel_pkg::S_IDLE;
          end
        end

        default: state <= bsp_sel_pkg::S_IDLE;
      endcase
    end
  end

endmodule
